[design/fbmh_pkg.sv]
// ----------------------------------------------------------------------------
// fbmh_pkg
// Shared types and constants of the free block max-heap.
// ----------------------------------------------------------------------------
package fbmh_pkg;
	localparam int unsigned CAPACITY_DEF  = 64;
	localparam int unsigned ID_BITS_DEF   = 16;
	localparam int unsigned SIZE_BITS_DEF = 16;

	localparam logic       OP_INSERT = 1'b0;
	localparam logic       OP_REMOVE = 1'b1;
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_MISS   = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic        op;
		logic [15:0] block_id;
		logic [15:0] blk_bytes;
	} fbmh_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        top_valid;
		logic [15:0] top_id;
		logic [15:0] top_size;
		logic [6:0]  entry_count;
	} fbmh_out_t;
endpackage

[design/free_block_max_heap_core.sv]
// ----------------------------------------------------------------------------
// free_block_max_heap_core
// Binary max-heap of free blocks keyed by size, with insert and remove by id.
// ----------------------------------------------------------------------------
// One item is taken at a time. The entry RAM has registered read data;
// the scan issues one read per cycle. Insert: sift-up, one parent read and
// compare per level, then the root is read and the result is posted.
// Remove: the scan up to the match, a fetch of the last entry, sift-down
// with reads of both children and a swap decision per level including the
// settling check, sift-up, then the root read and the result posting. A
// stalled result register holds the core in its wait state. The step costs
// are set by the single read port of the entry RAM. No clearing pass after
// reset: only entries below the fill count are used. The result waits in an
// output register; the next item can be taken while it is held.
module free_block_max_heap_core import fbmh_pkg::*; #(
	parameter int unsigned CAPACITY  = CAPACITY_DEF,
	parameter int unsigned ID_BITS   = ID_BITS_DEF,
	parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  fbmh_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output fbmh_out_t out_data
);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned EW = ID_BITS + SIZE_BITS;

	// states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;  // scan read issued, data next
	localparam logic [3:0] S_LAST  = 4'd2;  // last entry being read
	localparam logic [3:0] S_UPRD  = 4'd3;  // read parent
	localparam logic [3:0] S_UPCMP = 4'd4;  // compare parent with moving entry
	localparam logic [3:0] S_DNL   = 4'd5;  // left child read issued
	localparam logic [3:0] S_DNR   = 4'd6;  // right child read issued
	localparam logic [3:0] S_DNCMP = 4'd7;  // decide down swap
	localparam logic [3:0] S_ROOT  = 4'd8;  // root read issued
	localparam logic [3:0] S_FIN   = 4'd9;  // capture root
	localparam logic [3:0] S_WAIT  = 4'd10; // hold until output register frees

	logic [3:0]    state_q;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] pos_q, idx_q, best_q;
	logic [EW-1:0] cur_q, best_e_q;    // moving entry, best child entry
	logic [SIZE_BITS-1:0] best_sz;
	logic [ID_BITS-1:0]   key_q;
	logic [1:0]           status_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	fbmh_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [ID_BITS-1:0]   in_id;
	logic [SIZE_BITS-1:0] in_sz;
	assign in_id = ID_BITS'(in_data.block_id);
	assign in_sz = SIZE_BITS'(in_data.blk_bytes);

	logic [SIZE_BITS-1:0] cur_sz, rd_sz;
	logic [ID_BITS-1:0]   rd_id;
	assign cur_sz = cur_q[SIZE_BITS-1:0];
	assign rd_sz  = rdata[SIZE_BITS-1:0];
	assign rd_id  = rdata[EW-1:SIZE_BITS];
	assign best_sz = best_e_q[SIZE_BITS-1:0];

	// child indexes, widened so overflow past fill is caught
	logic [AW:0] lc, rc;
	assign lc = {pos_q, 1'b1};
	assign rc = {pos_q, 1'b0} + (AW+1)'(2);

	logic [AW-1:0] parent;
	assign parent = AW'((pos_q - AW'(1)) >> 1);

	logic out_free;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						key_q    <= in_id;
						cur_q    <= {in_id, in_sz};
						status_q <= ST_DONE;
						idx_q    <= '0;
						if (in_data.op == OP_INSERT) begin
							if (fill_q >= CW'(CAPACITY)) begin
								status_q <= ST_FULL;
								state_q  <= S_ROOT;
							end else begin
								// append now, sift from the new slot
								pos_q   <= AW'(fill_q);
								fill_q  <= fill_q + CW'(1);
								state_q <= S_UPRD;
							end
						end else if (fill_q == '0) begin
							status_q <= ST_MISS;
							state_q  <= S_ROOT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_id == key_q) begin
						// hole at idx_q; fetch last entry
						pos_q   <= idx_q;
						fill_q  <= fill_q - CW'(1);
						state_q <= S_LAST;
					end else if (CW'(idx_q) + CW'(1) >= fill_q) begin
						status_q <= ST_MISS;
						state_q  <= S_ROOT;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_LAST: begin
					cur_q <= rdata;
					if (CW'(pos_q) >= fill_q) begin
						state_q <= S_ROOT;  // removed the last slot
					end else begin
						best_q  <= pos_q;
						state_q <= S_DNL;
					end
				end
				S_DNL: begin
					best_q   <= pos_q;
					best_e_q <= cur_q;
					if ((AW+1)'(fill_q) > lc && rd_sz > cur_sz) begin
						best_q   <= AW'(lc);
						best_e_q <= rdata;
					end
					state_q <= S_DNR;
				end
				S_DNR: begin
					if ((AW+1)'(fill_q) > rc && rd_sz > best_sz) begin
						best_q   <= AW'(rc);
						best_e_q <= rdata;
					end
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					if (best_q == pos_q) begin
						state_q <= S_UPRD;  // settled; now try upward
					end else begin
						pos_q   <= best_q;
						state_q <= S_DNL;
					end
				end
				S_UPRD: begin
					state_q <= (pos_q == '0) ? S_ROOT : S_UPCMP;
				end
				S_UPCMP: begin
					if (rd_sz < cur_sz) begin
						pos_q   <= parent;
						state_q <= S_UPRD;
					end else begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: state_q <= S_FIN;
				S_FIN: state_q <= S_WAIT;
				S_WAIT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// root capture for the result
	logic [EW-1:0] root_q;
	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			root_q <= rdata;
		end
		if (state_q == S_WAIT && out_free) begin
			out_data.status      <= status_q;
			out_data.top_valid   <= (fill_q != '0);
			out_data.top_id      <= (fill_q != '0) ? 16'(root_q[EW-1:SIZE_BITS]) : '0;
			out_data.top_size    <= (fill_q != '0) ? 16'(root_q[SIZE_BITS-1:0]) : '0;
			out_data.entry_count <= 7'(fill_q);
		end
	end

	// memory port steering: the moving entry is written at pos when it rests and
	// at each sift-up step; a displaced neighbor is written into its slot.
	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = cur_q;
		raddr = pos_q;
		unique case (state_q)
			S_IDLE:  raddr = '0;
			S_SCAN:  raddr = idx_q + AW'(1);
			S_LAST:  raddr = AW'(lc);
			S_DNL:   raddr = AW'(rc);
			S_DNR:   raddr = pos_q;
			S_DNCMP: begin
				we = 1'b1;
				if (best_q == pos_q) begin
					wdata = cur_q;
				end else begin
					wdata = best_e_q;  // child moves up into pos
				end
				raddr = AW'({best_q, 1'b1});
			end
			S_UPRD: begin
				we    = 1'b1;      // moving entry placed at pos
				raddr = parent;
			end
			S_UPCMP: begin
				if (rd_sz < cur_sz) begin
					we    = 1'b1;
					wdata = rdata; // parent moves down
				end
				raddr = '0;
			end
			S_ROOT:  raddr = '0;
			S_FIN:   raddr = '0;
			S_WAIT:  raddr = '0;
			default: raddr = '0;
		endcase
		// scan first read comes from IDLE address 0; last entry read
		if (state_q == S_SCAN && rd_id == key_q) begin
			raddr = AW'(fill_q - CW'(1));
		end
	end

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY)) else $error("fill count past capacity");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");
`endif
endmodule

[design/fbmh_ram.sv]
// ----------------------------------------------------------------------------
// fbmh_ram
// Heap entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbmh_ram import fbmh_pkg::*; #(
	parameter int unsigned DEPTH = CAPACITY_DEF,
	parameter int unsigned WIDTH = ID_BITS_DEF + SIZE_BITS_DEF,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
